// ===== src/intel_hex_record_encoder_top_assert.svh =====
// Assertion macros shared by the Intel HEX encoder modules.
`ifndef INTEL_HEX_RECORD_ENCODER_TOP_ASSERT_SVH
`define INTEL_HEX_RECORD_ENCODER_TOP_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define IHEX_ASSERT_HOLDS(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define IHEX_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ihex_pkg.sv =====
// Package: types, constants and helpers of the Intel HEX encoder.
`timescale 1ns / 1ps
package ihex_pkg;

    localparam int RECORD_BYTES_DEF = 16;
    localparam int BYTE_W           = 8;
    localparam int ADDR_W           = 16;
    localparam int APB_ADDR_W       = 3;
    localparam int APB_DATA_W       = 32;
    localparam int END_LEN          = 11;
    localparam int SEQ_CNT_W        = 4;

    localparam logic CMD_DATA = 1'b0;
    localparam logic CMD_END  = 1'b1;

    localparam logic [APB_ADDR_W-1:0] REG_START_ADDRESS = 3'd0;

    localparam logic [BYTE_W-1:0] CH_COLON = 8'h3A;
    localparam logic [BYTE_W-1:0] CH_LF    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_EOF   = 8'h1A;

    typedef struct packed {
        logic              command;
        logic [BYTE_W-1:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_char;
        logic              last;
        logic              addr_overrun;
    } out_item_t;

    // One unit of work for the back end, built by the front end.
    typedef struct packed {
        logic              lead_nl;
        logic              do_rec;
        logic              do_end;
        logic              ovf;
        logic              bank;
        logic [BYTE_W-1:0] rec_count;
        logic [ADDR_W-1:0] rec_addr;
        logic [BYTE_W-1:0] hdr_sum;
    } job_t;

    typedef enum logic [3:0] {
        B_IDLE,
        B_LEAD,
        B_COLON,
        B_HDR,
        B_DATA,
        B_CSUM,
        B_RNL,
        B_END,
        B_ENL,
        B_EOF
    } back_state_t;

    function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] nib);
        logic [BYTE_W-1:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'h0, nib};
        end else begin
            ch = 8'h37 + {4'h0, nib};
        end
        return ch;
    endfunction

    // Characters of the end-of-file record ":00000001FF".
    function automatic logic [BYTE_W-1:0] end_char(input logic [SEQ_CNT_W-1:0] idx);
        logic [BYTE_W-1:0] ch;
        case (idx)
            4'd0:    ch = CH_COLON;
            4'd8:    ch = 8'h31;
            4'd9:    ch = 8'h46;
            4'd10:   ch = 8'h46;
            default: ch = 8'h30;
        endcase
        return ch;
    endfunction

endpackage

// ===== src/ihex_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ihex_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/ihex_queue.sv =====
// Two-entry job queue between the front end and the back end.
`timescale 1ns / 1ps
module ihex_queue (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           push,
    input  ihex_pkg::job_t push_job,
    output logic           full,
    output logic           valid,
    input  logic           pop,
    output ihex_pkg::job_t pop_job
);

    ihex_pkg::job_t entry_reg [2];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           do_push, do_pop;

    always_comb begin
        do_push     = push && (fill_reg != 2'd2);
        do_pop      = pop && (fill_reg != 2'd0);
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    assign full    = (fill_reg == 2'd2);
    assign valid   = (fill_reg != 2'd0);
    assign pop_job = entry_reg[rd_ptr_reg];

endmodule

// ===== src/ihex_front.sv =====
// Front end: takes input transactions, fills the record buffer and queues jobs.
`timescale 1ns / 1ps
module ihex_front #(
    parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  ihex_pkg::in_item_t                    s_item,
    input  logic                                  cfg_we,
    input  logic [ihex_pkg::ADDR_W-1:0]           cfg_wdata,
    output logic [ihex_pkg::ADDR_W-1:0]           start_address,
    input  logic                                  q_full,
    output logic                                  q_push,
    output ihex_pkg::job_t                        q_job,
    input  logic                                  rec_done,
    output logic                                  ram_we,
    output logic [$clog2(2*RECORD_BYTES)-1:0]     ram_waddr,
    output logic [ihex_pkg::BYTE_W-1:0]           ram_wdata
);

    localparam int CW = $clog2(RECORD_BYTES + 1);
    localparam int AW = $clog2(2 * RECORD_BYTES);

    logic [CW-1:0]               count_reg, count_next;
    logic [ihex_pkg::ADDR_W-1:0] addr_reg, addr_next;
    logic [ihex_pkg::ADDR_W-1:0] start_reg, start_next;
    logic                        lead_done_reg, lead_done_next;
    logic                        halted_reg, halted_next;
    logic                        bank_reg, bank_next;
    logic [1:0]                  rec_out_reg, rec_out_next;

    logic                        accept, work, is_data, full_rec, do_rec, ovf;
    logic [CW-1:0]               count_inc;
    logic [ihex_pkg::BYTE_W-1:0] rec_count;
    logic [ihex_pkg::ADDR_W:0]   addr_sum;

    always_comb begin
        s_ready   = halted_reg || (!q_full && (rec_out_reg != 2'd2));
        accept    = s_valid && s_ready;
        work      = accept && !halted_reg;
        is_data   = (s_item.command == ihex_pkg::CMD_DATA);
        count_inc = count_reg + 1'b1;
        full_rec  = (count_inc == CW'(RECORD_BYTES));
        do_rec    = is_data ? full_rec : (count_reg != '0);
        rec_count = is_data ? ihex_pkg::BYTE_W'(RECORD_BYTES) : ihex_pkg::BYTE_W'(count_reg);
        addr_sum  = {1'b0, addr_reg} + {{(ihex_pkg::ADDR_W - ihex_pkg::BYTE_W + 1){1'b0}}, rec_count};
        ovf       = do_rec && addr_sum[ihex_pkg::ADDR_W];

        q_push            = work && (do_rec || !is_data || !lead_done_reg);
        q_job.lead_nl     = !lead_done_reg;
        q_job.do_rec      = do_rec;
        q_job.do_end      = !is_data && !ovf;
        q_job.ovf         = ovf;
        q_job.bank        = bank_reg;
        q_job.rec_count   = rec_count;
        q_job.rec_addr    = addr_reg;
        q_job.hdr_sum     = rec_count + addr_reg[15:8] + addr_reg[7:0];

        ram_we    = work && is_data;
        ram_waddr = (bank_reg ? AW'(RECORD_BYTES) : '0) + AW'(count_reg);
        ram_wdata = s_item.data_byte;
    end

    always_comb begin
        count_next     = count_reg;
        addr_next      = addr_reg;
        start_next     = start_reg;
        lead_done_next = lead_done_reg;
        halted_next    = halted_reg;
        bank_next      = bank_reg;
        if (cfg_we) begin
            start_next = cfg_wdata;
            addr_next  = cfg_wdata;
        end else if (work) begin
            lead_done_next = 1'b1;
            if (is_data) begin
                count_next = full_rec ? '0 : count_inc;
            end
            if (do_rec) begin
                addr_next = addr_sum[ihex_pkg::ADDR_W-1:0];
                bank_next = ~bank_reg;
                if (ovf) begin
                    halted_next = 1'b1;
                end
            end
            // end of stream: rearm for a fresh one unless the address ran out
            if (!is_data) begin
                count_next = '0;
                if (!ovf) begin
                    addr_next      = start_reg;
                    lead_done_next = 1'b0;
                end
            end
        end
        rec_out_next = rec_out_reg + {1'b0, q_push && do_rec} - {1'b0, rec_done};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg     <= '0;
            addr_reg      <= '0;
            start_reg     <= '0;
            lead_done_reg <= 1'b0;
            halted_reg    <= 1'b0;
            bank_reg      <= 1'b0;
            rec_out_reg   <= 2'd0;
        end else begin
            count_reg     <= count_next;
            addr_reg      <= addr_next;
            start_reg     <= start_next;
            lead_done_reg <= lead_done_next;
            halted_reg    <= halted_next;
            bank_reg      <= bank_next;
            rec_out_reg   <= rec_out_next;
        end
    end

    assign start_address = start_reg;

`include "intel_hex_record_encoder_top_assert.svh"

    `IHEX_ASSERT_HOLDS(a_push_room, q_push, !q_full, "job pushed into a full queue")
    `IHEX_ASSERT_HOLDS(a_done_known, rec_done, rec_out_reg != 2'd0, "record done with none outstanding")
    `IHEX_ASSERT_NEXT(a_halt_sticky, halted_reg, halted_reg, "halt released without reset")

endmodule

// ===== src/ihex_back.sv =====
// Back end: sequences the text of each job, one character per transaction.
`timescale 1ns / 1ps
module ihex_back #(
    parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              q_valid,
    input  ihex_pkg::job_t                    q_job,
    output logic                              q_pop,
    output logic [$clog2(2*RECORD_BYTES)-1:0] ram_raddr,
    input  logic [ihex_pkg::BYTE_W-1:0]       ram_rdata,
    output logic                              rec_done,
    output logic                              m_valid,
    input  logic                              m_ready,
    output ihex_pkg::out_item_t               m_item
);

    localparam int AW = $clog2(2 * RECORD_BYTES);

    ihex_pkg::back_state_t              state_reg, state_next;
    ihex_pkg::job_t                     job_reg, job_next;
    logic [ihex_pkg::SEQ_CNT_W-1:0]     cnt_reg, cnt_next;
    logic [ihex_pkg::BYTE_W-1:0]        byte_idx_reg, byte_idx_next;
    logic [ihex_pkg::BYTE_W-1:0]        sum_reg, sum_next;
    logic                               m_valid_reg, m_valid_next;
    ihex_pkg::out_item_t                m_item_reg, m_item_next;

    logic                               out_free, emit, emit_en, last_byte;
    logic [ihex_pkg::BYTE_W-1:0]        hdr_byte, csum, nib_src;
    ihex_pkg::out_item_t                emit_item;

    assign out_free  = !m_valid_reg || m_ready;
    assign emit      = emit_en && out_free;
    assign last_byte = (byte_idx_reg == (job_reg.rec_count - 1'b1));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ihex_pkg::B_IDLE: begin
                if (q_valid) begin
                    if (q_job.lead_nl) begin
                        state_next = ihex_pkg::B_LEAD;
                    end else if (q_job.do_rec) begin
                        state_next = ihex_pkg::B_COLON;
                    end else begin
                        state_next = ihex_pkg::B_END;
                    end
                end
            end
            ihex_pkg::B_LEAD: begin
                if (emit) begin
                    if (job_reg.do_rec) begin
                        state_next = ihex_pkg::B_COLON;
                    end else if (job_reg.do_end) begin
                        state_next = ihex_pkg::B_END;
                    end else begin
                        state_next = ihex_pkg::B_IDLE;
                    end
                end
            end
            ihex_pkg::B_COLON: begin
                if (emit) begin
                    state_next = ihex_pkg::B_HDR;
                end
            end
            ihex_pkg::B_HDR: begin
                if (emit && (cnt_reg == 4'd7)) begin
                    state_next = ihex_pkg::B_DATA;
                end
            end
            ihex_pkg::B_DATA: begin
                if (emit && cnt_reg[0] && last_byte) begin
                    state_next = ihex_pkg::B_CSUM;
                end
            end
            ihex_pkg::B_CSUM: begin
                if (emit && cnt_reg[0]) begin
                    state_next = ihex_pkg::B_RNL;
                end
            end
            ihex_pkg::B_RNL: begin
                if (emit) begin
                    state_next = job_reg.do_end ? ihex_pkg::B_END : ihex_pkg::B_IDLE;
                end
            end
            ihex_pkg::B_END: begin
                if (emit && (cnt_reg == ihex_pkg::SEQ_CNT_W'(ihex_pkg::END_LEN - 1))) begin
                    state_next = ihex_pkg::B_ENL;
                end
            end
            ihex_pkg::B_ENL: begin
                if (emit) begin
                    state_next = ihex_pkg::B_EOF;
                end
            end
            ihex_pkg::B_EOF: begin
                if (emit) begin
                    state_next = ihex_pkg::B_IDLE;
                end
            end
            default: state_next = ihex_pkg::B_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        case (cnt_reg[2:1])
            2'd0:    hdr_byte = job_reg.rec_count;
            2'd1:    hdr_byte = job_reg.rec_addr[15:8];
            2'd2:    hdr_byte = job_reg.rec_addr[7:0];
            default: hdr_byte = 8'h00;
        endcase
        csum = 8'h00 - sum_reg;

        emit_en                = 1'b1;
        q_pop                  = 1'b0;
        rec_done               = 1'b0;
        nib_src                = hdr_byte;
        emit_item.out_char     = ihex_pkg::CH_LF;
        emit_item.last         = 1'b0;
        emit_item.addr_overrun = 1'b0;
        case (state_reg)
            ihex_pkg::B_IDLE: begin
                emit_en = 1'b0;
                q_pop   = q_valid;
            end
            ihex_pkg::B_LEAD: begin
                emit_item.last = !job_reg.do_rec && !job_reg.do_end;
            end
            ihex_pkg::B_COLON: begin
                emit_item.out_char = ihex_pkg::CH_COLON;
            end
            ihex_pkg::B_HDR: begin
                nib_src            = hdr_byte;
                emit_item.out_char = ihex_pkg::hex_char(cnt_reg[0] ? nib_src[3:0] : nib_src[7:4]);
            end
            ihex_pkg::B_DATA: begin
                nib_src            = ram_rdata;
                emit_item.out_char = ihex_pkg::hex_char(cnt_reg[0] ? nib_src[3:0] : nib_src[7:4]);
            end
            ihex_pkg::B_CSUM: begin
                nib_src            = csum;
                emit_item.out_char = ihex_pkg::hex_char(cnt_reg[0] ? nib_src[3:0] : nib_src[7:4]);
            end
            ihex_pkg::B_RNL: begin
                emit_item.last         = !job_reg.do_end;
                emit_item.addr_overrun = job_reg.ovf;
                rec_done               = emit;
            end
            ihex_pkg::B_END: begin
                emit_item.out_char = ihex_pkg::end_char(cnt_reg);
            end
            ihex_pkg::B_ENL: begin
                emit_item.out_char = ihex_pkg::CH_LF;
            end
            ihex_pkg::B_EOF: begin
                emit_item.out_char = ihex_pkg::CH_EOF;
                emit_item.last     = 1'b1;
            end
            default: begin
                emit_en = 1'b0;
            end
        endcase
    end

    // datapath and output register
    always_comb begin
        job_next      = q_pop ? q_job : job_reg;
        cnt_next      = cnt_reg;
        byte_idx_next = byte_idx_reg;
        sum_next      = sum_reg;
        if (state_next != state_reg) begin
            cnt_next = '0;
        end else if (emit) begin
            cnt_next = cnt_reg + 1'b1;
        end
        if (state_reg == ihex_pkg::B_IDLE) begin
            byte_idx_next = '0;
            sum_next      = q_job.hdr_sum;
        end else if ((state_reg == ihex_pkg::B_DATA) && emit && cnt_reg[0]) begin
            byte_idx_next = byte_idx_reg + 1'b1;
            sum_next      = sum_reg + ram_rdata;
        end
        // read ahead so the next byte is waiting when its high nibble goes out
        ram_raddr = (job_reg.bank ? AW'(RECORD_BYTES) : '0) + AW'(byte_idx_next);

        m_item_next  = m_item_reg;
        m_valid_next = m_valid_reg;
        if (emit) begin
            m_item_next  = emit_item;
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ihex_pkg::B_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg      <= job_next;
        cnt_reg      <= cnt_next;
        byte_idx_reg <= byte_idx_next;
        sum_reg      <= sum_next;
        m_item_reg   <= m_item_next;
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

`include "intel_hex_record_encoder_top_assert.svh"

    `IHEX_ASSERT_HOLDS(a_data_in_range, state_reg == ihex_pkg::B_DATA,
        byte_idx_reg < job_reg.rec_count, "record byte index past record length")
    `IHEX_ASSERT_HOLDS(a_err_no_end, emit && (state_reg == ihex_pkg::B_RNL) && job_reg.ovf,
        !job_reg.do_end, "end record queued after address overflow")
    `IHEX_ASSERT_HOLDS(a_eof_from_end, emit && (state_reg == ihex_pkg::B_EOF),
        job_reg.do_end, "end-of-file byte without end command")

endmodule

// ===== src/intel_hex_record_encoder_top.sv =====
// The first character of a job passes through the job queue, the back-end state register and
//   the output register, whether or not a leading line feed comes first.
// Throughput: one character per cycle from the back-end sequencer while m_ready holds,
//   with the back end returning to its idle state between jobs.
// Input bytes are taken at one per cycle until two records are outstanding or the queue fills.
// Reset (aresetn low, synchronous): start address 0, no bytes pending, leading line feed
//   armed, halt cleared; buffer contents are not cleared.
`timescale 1ns / 1ps
module intel_hex_record_encoder_top #(
    parameter int RECORD_BYTES = ihex_pkg::RECORD_BYTES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  ihex_pkg::in_item_t                  s_item,
    output logic                                m_valid,
    input  logic                                m_ready,
    output ihex_pkg::out_item_t                 m_item,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ihex_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [ihex_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [ihex_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int AW = $clog2(2 * RECORD_BYTES);

    logic                         cfg_we;
    logic [ihex_pkg::ADDR_W-1:0]  start_address;
    logic                         q_full, q_push, q_valid, q_pop, rec_done;
    ihex_pkg::job_t               q_in_job, q_out_job;
    logic                         ram_we;
    logic [AW-1:0]                ram_waddr, ram_raddr;
    logic [ihex_pkg::BYTE_W-1:0]  ram_wdata, ram_rdata;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready
                    && (paddr == ihex_pkg::REG_START_ADDRESS);
    assign prdata = (paddr == ihex_pkg::REG_START_ADDRESS)
                    ? {{(ihex_pkg::APB_DATA_W - ihex_pkg::ADDR_W){1'b0}}, start_address}
                    : '0;

    ihex_front #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_item        (s_item),
        .cfg_we        (cfg_we),
        .cfg_wdata     (pwdata[ihex_pkg::ADDR_W-1:0]),
        .start_address (start_address),
        .q_full        (q_full),
        .q_push        (q_push),
        .q_job         (q_in_job),
        .rec_done      (rec_done),
        .ram_we        (ram_we),
        .ram_waddr     (ram_waddr),
        .ram_wdata     (ram_wdata)
    );

    ihex_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_job (q_in_job),
        .full     (q_full),
        .valid    (q_valid),
        .pop      (q_pop),
        .pop_job  (q_out_job)
    );

    ihex_ram #(
        .WIDTH (ihex_pkg::BYTE_W),
        .DEPTH (2 * RECORD_BYTES)
    ) u_buf (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (1'b1),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ihex_back #(
        .RECORD_BYTES (RECORD_BYTES)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_job     (q_out_job),
        .q_pop     (q_pop),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata),
        .rec_done  (rec_done),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item)
    );

endmodule
